### design/tpcd_pkg.sv
// ----------------------------------------------------------------------------
// tpcd_pkg
// Shared types and constants for the transparent pixel color dilation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam int FRAME_WIDTH_RST  = 256;
	localparam int FRAME_HEIGHT_RST = 256;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// neighbor positions, in search priority order
	localparam int NBR_CNT = 8;
	localparam int NBR_UL  = 0;
	localparam int NBR_UP  = 1;
	localparam int NBR_UR  = 2;
	localparam int NBR_L   = 3;
	localparam int NBR_R   = 4;
	localparam int NBR_LL  = 5;
	localparam int NBR_DN  = 6;
	localparam int NBR_LR  = 7;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       last_pixel;
	} pix_out_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// one line store word: pixel two rows back and pixel one row back
	typedef struct packed {
		pixel_t older;
		pixel_t newer;
	} line_t;

	typedef struct packed {
		pixel_t             pix;
		logic               emit;
		logic               last;
		logic [NBR_CNT-1:0] nbr_ok;
	} q_item_t;

endpackage

`default_nettype wire

### design/transparent_pixel_color_dilation.sv
// ----------------------------------------------------------------------------
// transparent_pixel_color_dilation
// Fills transparent RGBA8 pixels with the color of an opaque 3x3 neighbor.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one RGBA8 pixel per transaction in raster order, req_type 0.
//   After the last pixel send frame_width+1 padding transactions (req_type 1)
//   to flush the frame; early padding is taken and dropped.
//   rsp channel: every pixel returns frame_width+1 transactions after it went
//   in, alpha unchanged; last_pixel marks the final pixel of the frame.
//   cfg channel: index 0 frame_width, index 1 frame_height; a write restarts
//   the frame. cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One transaction per clock while results are taken. A result released by
//   a transaction reaches rsp through the queue, line store read and fill.
// Reset:
//   Counters clear, both sizes return to 256. The line store is not cleared;
//   entries are read only after the current frame wrote them.
// Backpressure:
//   When a result waits with rsp_ready low the result register holds, the back
//   pipeline stops and req_ready drops once the 4-entry queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_pixel_color_dilation import tpcd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire pix_in_t               req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output pix_out_t                   rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic          q_full;
	logic          q_push;
	q_item_t       q_item;
	logic          q_pop;
	logic          q_valid;
	q_item_t       q_head;
	logic [WW-1:0] line_w;
	logic          line_clr;

	tpcd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item),
		.line_w    (line_w),
		.line_clr  (line_clr)
	);

	tpcd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	tpcd_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.line_w    (line_w),
		.line_clr  (line_clr),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### design/tpcd_ram.sv
// ----------------------------------------------------------------------------
// tpcd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/tpcd_front.sv
// ----------------------------------------------------------------------------
// tpcd_front
// Accepts transactions, tracks the frame position and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcd_front import tpcd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire pix_in_t                         req,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0]           cfg_data,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output q_item_t                              q_item,
	output logic [$clog2(MAX_WIDTH+1)-1:0]       line_w,
	output logic                                 line_clr
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DW    = $clog2(MAX_WIDTH + 2);
	localparam int CMP_A = (WW > HW) ? WW : HW;
	localparam int CMP_W = (CMP_A > CFG_DATA_W) ? CMP_A : CFG_DATA_W;
	localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic [CW-1:0]    in_col_q;
	logic [RW-1:0]    in_row_q;
	logic             all_in_q;
	logic [DW-1:0]    dly_q;
	logic [CW-1:0]    out_col_q;
	logic [RW-1:0]    out_row_q;

	logic             acc;
	logic             cfg_wr;
	logic             drop;
	logic             emit;
	logic             last;
	logic             at_top;
	logic             at_bot;
	logic             at_lft;
	logic             at_rgt;
	logic             in_eol;
	logic             in_eof;
	logic [CMP_W-1:0] cfg_ext;
	logic [WW-1:0]    w_new;
	logic [HW-1:0]    h_new;

	assign req_ready = !q_full;
	assign cfg_ready = 1'b1;
	assign acc       = req_valid && req_ready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign line_w    = w_q;
	assign line_clr  = cfg_wr && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

	// sizes of zero act as one, oversize values saturate
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext == '0) begin
			w_new = WW'(1);
			h_new = HW'(1);
		end else begin
			w_new = (cfg_ext > CMP_W'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_ext);
			h_new = (cfg_ext > CMP_W'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_ext);
		end
	end

	always_comb begin
		// padding before the frame is complete is dropped
		drop   = req.req_type && !all_in_q;
		emit   = dly_q == (DW'(w_q) + DW'(1));
		at_top = out_row_q == '0;
		at_bot = out_row_q == RW'(h_q - HW'(1));
		at_lft = out_col_q == '0;
		at_rgt = out_col_q == CW'(w_q - WW'(1));
		last   = emit && at_bot && at_rgt;
		in_eol = in_col_q == CW'(w_q - WW'(1));
		in_eof = in_eol && (in_row_q == RW'(h_q - HW'(1)));

		q_push            = acc && !drop;
		q_item.pix.red    = req.in_red;
		q_item.pix.green  = req.in_green;
		q_item.pix.blue   = req.in_blue;
		q_item.pix.alpha  = req.in_alpha;
		q_item.emit       = emit;
		q_item.last       = last;
		q_item.nbr_ok[NBR_UL] = !at_top && !at_lft;
		q_item.nbr_ok[NBR_UP] = !at_top;
		q_item.nbr_ok[NBR_UR] = !at_top && !at_rgt;
		q_item.nbr_ok[NBR_L]  = !at_lft;
		q_item.nbr_ok[NBR_R]  = !at_rgt;
		q_item.nbr_ok[NBR_LL] = !at_bot && !at_lft;
		q_item.nbr_ok[NBR_DN] = !at_bot;
		q_item.nbr_ok[NBR_LR] = !at_bot && !at_rgt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= WW'(W_RST);
			h_q       <= HW'(H_RST);
			in_col_q  <= '0;
			in_row_q  <= '0;
			all_in_q  <= 1'b0;
			dly_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: begin
					w_q <= w_new;
				end
				CFG_FRAME_HEIGHT: begin
					h_q <= h_new;
				end
				default: begin
				end
			endcase
			if (line_clr) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				all_in_q  <= 1'b0;
				dly_q     <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end else if (q_push) begin
			if (last) begin
				// frame done: restart all counters
				in_col_q  <= '0;
				in_row_q  <= '0;
				all_in_q  <= 1'b0;
				dly_q     <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (!all_in_q) begin
					if (in_eof) begin
						all_in_q <= 1'b1;
					end else if (in_eol) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + RW'(1);
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (!emit) begin
					dly_q <= dly_q + DW'(1);
				end else if (at_rgt) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_item.last) |-> all_in_q)
		else $error("frame end flagged before all pixels were taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_item.last) |=> (dly_q == '0 && !all_in_q && out_row_q == '0))
		else $error("counters did not restart after frame end");
`endif

endmodule

`default_nettype wire

### design/tpcd_fifo.sv
// ----------------------------------------------------------------------------
// tpcd_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcd_fifo import tpcd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire q_item_t push_item,
	output logic         full,
	input  wire logic    pop,
	output logic         head_valid,
	output q_item_t      head
);

	localparam int CNT_W = QUEUE_AW + 1;

	q_item_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### design/tpcd_back.sv
// ----------------------------------------------------------------------------
// tpcd_back
// Line store, 3x3 window and neighbor color fill, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcd_back import tpcd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_valid,
	input  wire q_item_t                         q_head,
	output logic                                 q_pop,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  line_w,
	input  wire logic                            line_clr,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output pix_out_t                             rsp
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic          en;
	logic [CW-1:0] ptr_q;

	logic          s1_valid;
	q_item_t       s1_item;
	logic [CW-1:0] s1_ptr;
	logic          s2_valid;
	q_item_t       s2_item;
	logic [CW-1:0] s2_ptr;
	logic          byp_s2;
	line_t         byp_line_s2;

	line_t         ram_rd;
	line_t         line;
	line_t         line_wr;

	pixel_t        top_1_q;
	pixel_t        top_2_q;
	pixel_t        mid_1_q;
	pixel_t        mid_2_q;
	pixel_t        bot_1_q;
	pixel_t        bot_2_q;

	pixel_t        nbr [NBR_CNT];
	pixel_t        center;
	pixel_t        fill;
	logic          found;
	logic          rsp_valid_q;
	pix_out_t      rsp_q;

	// the whole back pipeline advances unless the result register is held
	assign en        = !rsp_valid_q || rsp_ready;
	assign q_pop     = en && q_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tpcd_ram #(
		.WIDTH ($bits(line_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (en && s2_valid),
		.waddr (s2_ptr),
		.wdata (line_wr),
		.re    (en && s1_valid),
		.raddr (s1_ptr),
		.rdata (ram_rd)
	);

	always_comb begin
		// forward the word written in the same cycle as the read (one-pixel rows)
		line          = byp_s2 ? byp_line_s2 : ram_rd;
		line_wr.older = line.newer;
		line_wr.newer = s2_item.pix;

		nbr[NBR_UL] = top_2_q;
		nbr[NBR_UP] = top_1_q;
		nbr[NBR_UR] = line.older;
		nbr[NBR_L]  = mid_2_q;
		nbr[NBR_R]  = line.newer;
		nbr[NBR_LL] = bot_2_q;
		nbr[NBR_DN] = bot_1_q;
		nbr[NBR_LR] = s2_item.pix;
		center      = mid_1_q;

		fill  = center;
		found = 1'b0;
		for (int i = 0; i < NBR_CNT; i++) begin
			if (!found && center.alpha == '0 && s2_item.nbr_ok[i] && nbr[i].alpha != '0) begin
				fill  = nbr[i];
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			byp_s2      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (line_clr) begin
				ptr_q <= '0;
			end else if (q_pop) begin
				ptr_q <= (ptr_q == CW'(line_w - WW'(1))) ? '0 : ptr_q + CW'(1);
			end
			if (en) begin
				s1_valid    <= q_valid;
				s2_valid    <= s1_valid;
				byp_s2      <= s1_valid && s2_valid && (s1_ptr == s2_ptr);
				rsp_valid_q <= s2_valid && s2_item.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_item     <= q_head;
			s1_ptr      <= ptr_q;
			s2_item     <= s1_item;
			s2_ptr      <= s1_ptr;
			byp_line_s2 <= line_wr;

			rsp_q.out_red    <= fill.red;
			rsp_q.out_green  <= fill.green;
			rsp_q.out_blue   <= fill.blue;
			rsp_q.out_alpha  <= center.alpha;
			rsp_q.last_pixel <= s2_item.last;

			// shift the window by one pixel
			if (s2_valid) begin
				top_2_q <= top_1_q;
				top_1_q <= line.older;
				mid_2_q <= mid_1_q;
				mid_1_q <= line.newer;
				bot_2_q <= bot_1_q;
				bot_1_q <= s2_item.pix;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && s1_valid && s2_valid && s1_ptr == s2_ptr) |-> (line_w == WW'(1)))
		else $error("line store read and write collide on a row wider than one pixel");
`endif

endmodule

`default_nettype wire

### dv/tpcd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpcd_checker
// Watches the request, response and configuration channels of the color
// dilation block, predicts every filled pixel from the accepted transactions
// and compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tpcd_checker import tpcd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire pix_in_t               req,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire pix_out_t              rsp,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         failures,
	output int                         outstanding
);

	localparam int HISTORY_DEPTH = 2 * MAX_WIDTH + 2;
	localparam int REPORT_LIMIT  = 10;
	localparam int EXPECT_DEPTH  = 64;

	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	pixel_t                pixel_history [HISTORY_DEPTH];
	int unsigned           pixels_taken;
	int unsigned           emit_col;
	int unsigned           emit_row;
	pix_out_t              expected_pixels [EXPECT_DEPTH];
	int unsigned           exp_wr;
	int unsigned           exp_rd;
	int                    fail_total;

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic restart_frame();
		pixels_taken = 0;
		emit_col     = 0;
		emit_row     = 0;
	endtask

	// advance the frame by one request transaction, queue the pixel it releases
	task automatic predict_fill(input pix_in_t item);
		int unsigned w, h, npix, total, span, n, idx;
		int          r, c, dy, dx;
		pixel_t      cur, center, nb;
		logic [23:0] rgb;
		bit          found;
		pix_out_t    res;
		w     = clamp_size(width_reg, MAX_WIDTH);
		h     = clamp_size(height_reg, MAX_HEIGHT);
		npix  = w * h;
		total = npix + w + 1;
		span  = 2 * w + 2;
		n     = pixels_taken;
		// drop padding until every pixel of the frame is in
		if (item.req_type && n < npix) return;
		cur = '{red: item.in_red, green: item.in_green, blue: item.in_blue,
			alpha: item.in_alpha};
		if (n >= w + 1) begin
			center = pixel_history[(n - w - 1) % span];
			rgb    = {center.red, center.green, center.blue};
			found  = 1'b0;
			if (center.alpha == 8'd0) begin
				for (dy = -1; dy <= 1; dy++) begin
					for (dx = -1; dx <= 1; dx++) begin
						r = int'(emit_row) + dy;
						c = int'(emit_col) + dx;
						if (!found && !(dy == 0 && dx == 0) && r >= 0 && c >= 0 &&
							r < int'(h) && c < int'(w)) begin
							idx = r * w + c;
							// the lower-right neighbor is the pixel arriving right now
							nb = (idx == n) ? cur : pixel_history[idx % span];
							if (nb.alpha != 8'd0) begin
								rgb   = {nb.red, nb.green, nb.blue};
								found = 1'b1;
							end
						end
					end
				end
			end
			res = '{out_red: rgb[23:16], out_green: rgb[15:8], out_blue: rgb[7:0],
				out_alpha: center.alpha, last_pixel: (n == total - 1)};
			expected_pixels[exp_wr % EXPECT_DEPTH] = res;
			exp_wr++;
			emit_col++;
			if (emit_col >= w) begin
				emit_col = 0;
				emit_row++;
			end
		end
		if (n < npix) pixel_history[n % span] = cur;
		n++;
		if (n >= total) restart_frame();
		else pixels_taken = n;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		pix_out_t want;
		if (!arst_n) begin
			width_reg  = CFG_DATA_W'(FRAME_WIDTH_RST);
			height_reg = CFG_DATA_W'(FRAME_HEIGHT_RST);
			restart_frame();
			exp_wr     = 0;
			exp_rd     = 0;
			fail_total = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: begin
						width_reg = cfg_data;
						restart_frame();
					end
					CFG_FRAME_HEIGHT: begin
						height_reg = cfg_data;
						restart_frame();
					end
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (exp_wr == exp_rd) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("unexpected response transaction: r=%h g=%h b=%h a=%h last=%b",
							rsp.out_red, rsp.out_green, rsp.out_blue, rsp.out_alpha,
							rsp.last_pixel);
				end else begin
					want = expected_pixels[exp_rd % EXPECT_DEPTH];
					exp_rd++;
					if (rsp.out_red !== want.out_red || rsp.out_green !== want.out_green ||
						rsp.out_blue !== want.out_blue || rsp.out_alpha !== want.out_alpha ||
						rsp.last_pixel !== want.last_pixel) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT)
							$display("pixel mismatch: expected r=%h g=%h b=%h a=%h last=%b,",
								want.out_red, want.out_green, want.out_blue,
								want.out_alpha, want.last_pixel,
								" got r=%h g=%h b=%h a=%h last=%b",
								rsp.out_red, rsp.out_green, rsp.out_blue,
								rsp.out_alpha, rsp.last_pixel);
					end
				end
			end
			if (req_valid && req_ready) predict_fill(req);
			failures    <= fail_total;
			outstanding <= int'(exp_wr - exp_rd);
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the transparent pixel color dilation block: a directed pass
// over the corner cases, then randomized frames of many sizes and alpha
// mixes with random idling on both channels, then the first pixels of the widest
// and tallest frames. A checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb import tpcd_pkg::*;;

	typedef enum int {ALPHA_MIXED, ALPHA_SPARSE, ALPHA_NONE, ALPHA_DENSE} alpha_mix_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int    SETTLE_CYCLES = 8;
	localparam int    HOLD_CYCLES   = 400;
	localparam int    RANDOM_ITEMS  = 740;
	localparam longint SIM_LIMIT_NS = 64'd25_000_000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	pix_in_t               req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	pix_out_t              rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  squeeze   = 1'b0;
	int                    mismatches;
	int                    outstanding;
	bit                    burst;
	int                    frame_w;
	int                    frame_h;

	transparent_pixel_color_dilation dut (
		.clk, .arst_n,
		.req_valid, .req_ready, .req,
		.rsp_valid, .rsp_ready, .rsp,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	tpcd_checker checker_i (
		.clk, .arst_n,
		.req_valid, .req_ready, .req,
		.rsp_valid, .rsp_ready, .rsp,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.failures(mismatches), .outstanding
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_in_t pixel_item(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		return '{req_type: 1'b0, in_red: r, in_green: g, in_blue: b, in_alpha: a};
	endfunction

	function automatic pix_in_t pad_item();
		return {1'b1, 32'($urandom)};
	endfunction

	function automatic pix_in_t random_pixel(input alpha_mix_t mix);
		logic [7:0] a;
		a = 8'($urandom_range(1, 255));
		case (mix)
			ALPHA_MIXED:  if ($urandom_range(0, 1) != 0) a = 8'd0;
			ALPHA_SPARSE: if ($urandom_range(0, 7) != 0) a = 8'd0;
			ALPHA_NONE:   a = 8'd0;
			default:      if ($urandom_range(0, 7) == 0) a = 8'd0;
		endcase
		return pixel_item(8'($urandom), 8'($urandom), 8'($urandom), a);
	endfunction

	// offer one request transaction, hold it until accepted
	task automatic push_item(input pix_in_t item);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// wait for every predicted pixel, then let the pipeline empty
	task automatic drain();
		int quiet;
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		quiet = 0;
		while (quiet < SETTLE_CYCLES) begin
			@(posedge clk);
			if (rsp_ready) quiet++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input int w_raw, input int h_raw, input bit spare);
		drain();
		if ($urandom_range(0, 1) != 0) begin
			write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_raw));
			write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
		end else begin
			write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
			write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_raw));
		end
		if (spare)
			write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		frame_w = (w_raw < 1) ? 1 : (w_raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_raw;
		frame_h = (h_raw < 1) ? 1 : (h_raw > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_raw;
	endtask

	// one frame plus flush; stop after cut pixels when cut is not negative
	task automatic send_frame(input alpha_mix_t mix, input int cut, inout int count);
		int npix, k;
		npix = frame_w * frame_h;
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) push_item(pad_item());
		for (k = 0; k < npix; k++) begin
			if (k == cut) return;
			if ($urandom_range(0, 31) == 0) push_item(pad_item());
			push_item(random_pixel(mix));
			count++;
		end
		for (k = 0; k <= frame_w; k++) begin
			// a pixel in the flush stands in for padding
			if ($urandom_range(0, 5) == 0) push_item(random_pixel(ALPHA_MIXED));
			else push_item(pad_item());
			count++;
		end
		if ($urandom_range(0, 7) == 0) push_item(pad_item());
	endtask

	task automatic directed();
		// padding with no frame under way
		push_item(pad_item());
		configure(3, 3, 1'b0);
		push_item(pixel_item(8'h11, 8'h22, 8'h33, 8'h01));
		push_item(pixel_item(8'hff, 8'hff, 8'hff, 8'h00));
		push_item(pixel_item(8'h00, 8'h00, 8'h00, 8'h00));
		push_item(pixel_item(8'h44, 8'h55, 8'h66, 8'hff));
		push_item(pad_item());
		push_item(pixel_item(8'haa, 8'hbb, 8'hcc, 8'h00));
		push_item(pixel_item(8'h12, 8'h34, 8'h56, 8'h00));
		push_item(pixel_item(8'h9a, 8'hbc, 8'hde, 8'h00));
		push_item(pixel_item(8'h01, 8'h02, 8'h03, 8'h00));
		push_item(pixel_item(8'hfe, 8'hdc, 8'hba, 8'h80));
		push_item(pad_item());
		push_item(pixel_item(8'h5a, 8'ha5, 8'h3c, 8'h7f));
		push_item(pad_item());
		push_item(pad_item());
		push_item(pad_item());
		// zero sizes act as one
		configure(0, 0, 1'b1);
		push_item(pixel_item(8'hff, 8'h00, 8'hff, 8'h00));
		push_item(pad_item());
		push_item(pad_item());
		// a spare index leaves the frame running, a real write restarts it
		configure(2, 2, 1'b0);
		repeat (3) push_item(random_pixel(ALPHA_MIXED));
		drain();
		write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		push_item(random_pixel(ALPHA_MIXED));
		push_item(pad_item());
		configure(2, 2, 1'b0);
	endtask

	task automatic random_frames();
		int sent, frames, f, cut;
		bit spare;
		sent = 0;
		// large frame streaming while the receiver holds off
		configure(16, 16, 1'b0);
		burst = 1'b1;
		squeeze <= 1'b1;
		send_frame(ALPHA_MIXED, -1, sent);
		while (sent < RANDOM_ITEMS) begin
			spare = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0:       configure(1, $urandom_range(1, 12), spare);
				1:       configure($urandom_range(1, 40), 1, spare);
				8:       configure($urandom_range(11, 40), $urandom_range(2, 5), spare);
				9:       configure(0, $urandom_range(0, 6), spare);
				default: configure($urandom_range(2, 10), $urandom_range(2, 8), spare);
			endcase
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				burst = ($urandom_range(0, 4) == 0);
				cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, frame_w * frame_h) : -1;
				send_frame(alpha_mix_t'($urandom_range(0, 3)), cut, sent);
				// a broken frame ends the phase; the next write restarts it
				if (cut >= 0) break;
			end
		end
	endtask

	initial begin : stimulus
		int spent;
		spent = 0;
		burst = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		random_frames();
		// sizes above the maximum act as the maximum; start such frames only
		burst = 1'b0;
		configure(2047, 1, 1'b0);
		send_frame(ALPHA_SPARSE, 24, spent);
		configure(1, 2047, 1'b1);
		send_frame(ALPHA_MIXED, 40, spent);
		drain();
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : sink
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze && !held) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					rsp_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 4) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
				else repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#(SIM_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
